>>> src/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine: command and status
// codes, controller states, datapath operations and datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

  // Defaults for the top level parameters
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the channel words
  localparam int CMD_W  = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_INSERT     = 4'd4,
    CMD_REMOVE     = 4'd5,
    CMD_GET        = 4'd6,
    CMD_FIND       = 4'd7,
    CMD_CLEAR      = 4'd8
  } ole_cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_INDEX = 2'd2,
    ST_FULL  = 2'd3
  } ole_status_t;

  // Command class after decode
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INS,
    KIND_REM,
    KIND_GET,
    KIND_FIND,
    KIND_CLR
  } ole_kind_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DECODE,
    OP_MOVE_RD,
    OP_MOVE_WR,
    OP_PUT,
    OP_SHRINK,
    OP_GET_RD,
    OP_GET_CAP,
    OP_FIND_RD,
    OP_FIND_CMP,
    OP_FRONT_RD,
    OP_BACK_RD,
    OP_BACK_CAP,
    OP_OUT
  } ole_op_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_SHRINK,
    S_GET_RD,
    S_GET_CAP,
    S_FIND_RD,
    S_FIND_CMP,
    S_FRONT_RD,
    S_BACK_RD,
    S_BACK_CAP,
    S_DONE
  } ole_state_t;

  // Datapath status seen by the controller
  typedef struct packed {
    ole_kind_t dec_kind;     // class of the loaded command
    logic      dec_err;      // command is rejected, state unchanged
    logic      dec_no_move;  // no entry has to shift
    logic      count_zero;   // list is empty
    ole_kind_t cur_kind;     // class latched at decode
    logic      move_last;    // current shift step is the final one
    logic      find_last;    // current compare is on the last entry
    logic      out_busy;     // result register still holds an untaken word
  } ole_dp_stat_t;

endpackage

`default_nettype wire

>>> src/ole_in_if.sv
// ----------------------------------------------------------------------------
// ole_in_if
// Command channel: valid/ready handshake with command, value and position.
// ----------------------------------------------------------------------------
`default_nettype none

interface ole_in_if
  import ole_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, output command, output value, output position,
                  input ready);
  modport sink   (input valid, input command, input value, input position,
                  output ready);
endinterface

`default_nettype wire

>>> src/ole_out_if.sv
// ----------------------------------------------------------------------------
// ole_out_if
// Result channel: valid/ready handshake with status, read value, found flag,
// front and back values and entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface ole_out_if
  import ole_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] read_value;
  logic                    found;
  logic signed [VAL_W-1:0] front_value;
  logic signed [VAL_W-1:0] back_value;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, output status, output read_value, output found,
                  output front_value, output back_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input found,
                  input front_value, input back_value, input entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> src/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Ordered list of up to CAPACITY signed words with deque and indexed access.
// ----------------------------------------------------------------------------
// The list lives in a single-port-write, registered-read RAM in index order,
// and the engine works one command at a time. A command is taken only while
// the engine is idle; a finished result waits in the output register, so the
// next command may be taken and run while it is still unread. A get reads one
// entry, a find reads and compares each entry in turn, and a push, pop,
// insert or remove first shifts the entries that must move to open or close
// the gap. The shift and the search move one entry at a time (read, then
// write or compare) through the one RAM read port; after a push, pop, insert
// or remove the front and back entries are read back into registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_unit
  import ole_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ole_in_if.sink      in_chan,
  ole_out_if.source   out_chan
);

  ole_op_t      op;
  ole_dp_stat_t stat;
  logic         in_ready;

  assign in_chan.ready = in_ready;

  // controller
  ole_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  // datapath
  ole_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .stat            (stat),
    .in_command      (in_chan.command),
    .in_value        (in_chan.value),
    .in_position     (in_chan.position),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_read_value  (out_chan.read_value),
    .out_found       (out_chan.found),
    .out_front_value (out_chan.front_value),
    .out_back_value  (out_chan.back_value),
    .out_entry_count (out_chan.entry_count)
  );

endmodule

`default_nettype wire

>>> src/ole_ram.sv
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/ole_ctrl.sv
// ----------------------------------------------------------------------------
// ole_ctrl
// Controller of the ordered list engine: sequences decode, entry shifts,
// reads, the search scan, the front/back refresh and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ctrl
  import ole_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire ole_dp_stat_t stat,
  output ole_op_t           op
);

  ole_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (stat.dec_err) begin
          state_nxt = S_DONE;
        end else begin
          case (stat.dec_kind)
            KIND_INS:  state_nxt = stat.dec_no_move ? S_PUT : S_MOVE_RD;
            KIND_REM:  state_nxt = stat.dec_no_move ? S_SHRINK : S_MOVE_RD;
            KIND_GET:  state_nxt = S_GET_RD;
            KIND_FIND: state_nxt = stat.count_zero ? S_DONE : S_FIND_RD;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_MOVE_RD: state_nxt = S_MOVE_WR;
      S_MOVE_WR: begin
        if (stat.move_last) begin
          state_nxt = (stat.cur_kind == KIND_INS) ? S_PUT : S_SHRINK;
        end else begin
          state_nxt = S_MOVE_RD;
        end
      end
      S_PUT:      state_nxt = S_FRONT_RD;
      S_SHRINK:   state_nxt = S_FRONT_RD;
      S_GET_RD:   state_nxt = S_GET_CAP;
      S_GET_CAP:  state_nxt = S_DONE;
      S_FIND_RD:  state_nxt = S_FIND_CMP;
      S_FIND_CMP: state_nxt = stat.find_last ? S_DONE : S_FIND_RD;
      S_FRONT_RD: state_nxt = S_BACK_RD;
      S_BACK_RD:  state_nxt = S_BACK_CAP;
      S_BACK_CAP: state_nxt = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    op       = OP_IDLE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        op       = in_valid ? OP_LOAD : OP_IDLE;
      end
      S_DECODE:   op = OP_DECODE;
      S_MOVE_RD:  op = OP_MOVE_RD;
      S_MOVE_WR:  op = OP_MOVE_WR;
      S_PUT:      op = OP_PUT;
      S_SHRINK:   op = OP_SHRINK;
      S_GET_RD:   op = OP_GET_RD;
      S_GET_CAP:  op = OP_GET_CAP;
      S_FIND_RD:  op = OP_FIND_RD;
      S_FIND_CMP: op = OP_FIND_CMP;
      S_FRONT_RD: op = OP_FRONT_RD;
      S_BACK_RD:  op = OP_BACK_RD;
      S_BACK_CAP: op = OP_BACK_CAP;
      S_DONE:     op = stat.out_busy ? OP_IDLE : OP_OUT;
      default:    op = OP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/ole_dp.sv
// ----------------------------------------------------------------------------
// ole_dp
// Datapath of the ordered list engine: command registers, decode, entry
// count, shift index, entry RAM, front/back copies and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_dp
  import ole_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ole_op_t                 op,
  output ole_dp_stat_t                 stat,
  // command word
  input  wire logic [CMD_W-1:0]        in_command,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic [POS_W-1:0]        in_position,
  // result word
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [STAT_W-1:0]            out_status,
  output logic signed [VAL_W-1:0]      out_read_value,
  output logic                         out_found,
  output logic signed [VAL_W-1:0]      out_front_value,
  output logic signed [VAL_W-1:0]      out_back_value,
  output logic [CNT_W-1:0]             out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int DW = DATA_WIDTH;

  // command registers
  ole_cmd_t               cmd_r;
  logic signed [DW-1:0]   val_r;
  logic [POS_W-1:0]       pos_r;

  // list state and sequencing
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          idx_r;
  logic [CW-1:0]          at_r;
  ole_kind_t              kind_r;
  ole_status_t            status_r;
  logic signed [DW-1:0]   rd_r;
  logic                   hit_r;
  logic signed [DW-1:0]   front_r;
  logic signed [DW-1:0]   back_r;

  // RAM ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [DW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [DW-1:0]          ram_rdata;

  // decode
  ole_kind_t              dec_kind;
  ole_status_t            dec_status;
  logic [CW-1:0]          dec_at;
  logic                   dec_no_move;
  logic                   full;
  logic                   empty;
  logic                   pos_ge;
  logic [CW:0]            at_p1;

  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);
  assign pos_ge = (PW'(pos_r) >= PW'(count_r));

  always_comb begin
    dec_kind    = KIND_NONE;
    dec_status  = ST_OK;
    dec_at      = '0;
    case (cmd_r)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        dec_kind = KIND_INS;
        if (full) dec_status = ST_FULL;
        if (cmd_r == CMD_PUSH_FRONT) begin
          dec_at = '0;
        end else if (cmd_r == CMD_PUSH_BACK || pos_ge) begin
          dec_at = count_r;
        end else begin
          dec_at = CW'(pos_r);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE: begin
        dec_kind = KIND_REM;
        if (cmd_r == CMD_POP_FRONT) begin
          dec_at = '0;
        end else if (cmd_r == CMD_POP_BACK) begin
          dec_at = count_r - CW'(1);
        end else begin
          dec_at = CW'(pos_r);
        end
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (cmd_r == CMD_REMOVE && pos_ge) begin
          dec_status = ST_INDEX;
        end
      end
      CMD_GET: begin
        dec_kind = KIND_GET;
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_ge) begin
          dec_status = ST_INDEX;
        end
      end
      CMD_FIND:  dec_kind = KIND_FIND;
      CMD_CLEAR: dec_kind = KIND_CLR;
      default:   dec_kind = KIND_NONE;
    endcase
  end

  // nothing to shift: insert lands past the last entry, or removal of the last
  assign at_p1 = {1'b0, dec_at} + (CW+1)'(1);
  always_comb begin
    if (dec_kind == KIND_INS) begin
      dec_no_move = (dec_at == count_r);
    end else begin
      dec_no_move = (at_p1 >= {1'b0, count_r});
    end
  end

  // status toward the controller
  always_comb begin
    stat.dec_kind    = dec_kind;
    stat.dec_err     = (dec_status != ST_OK);
    stat.dec_no_move = dec_no_move;
    stat.count_zero  = empty;
    stat.cur_kind    = kind_r;
    if (kind_r == KIND_INS) begin
      stat.move_last = ({1'b0, idx_r} == ({1'b0, at_r} + (CW+1)'(1)));
    end else begin
      stat.move_last = (({1'b0, idx_r} + (CW+1)'(2)) >= {1'b0, count_r});
    end
    stat.find_last = (({1'b0, idx_r} + (CW+1)'(1)) >= {1'b0, count_r});
    stat.out_busy  = out_valid & ~out_ready;
  end

  // RAM address and write selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(idx_r);
    ram_wdata = ram_rdata;
    ram_raddr = AW'(idx_r);
    case (op)
      OP_MOVE_RD: begin
        if (kind_r == KIND_INS) begin
          ram_raddr = AW'(idx_r - CW'(1));
        end else begin
          ram_raddr = AW'(idx_r + CW'(1));
        end
      end
      OP_MOVE_WR: ram_we = 1'b1;
      OP_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(at_r);
        ram_wdata = val_r;
      end
      OP_GET_RD:   ram_raddr = AW'(pos_r);
      OP_FRONT_RD: ram_raddr = '0;
      OP_BACK_RD:  ram_raddr = AW'(count_r - CW'(1));
      default:     ram_raddr = AW'(idx_r);
    endcase
  end

  ole_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers: count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op == OP_DECODE && dec_kind == KIND_CLR) begin
        count_r <= '0;
      end else if (op == OP_PUT) begin
        count_r <= count_r + CW'(1);
      end else if (op == OP_SHRINK) begin
        count_r <= count_r - CW'(1);
      end
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd_r <= ole_cmd_t'(in_command);
        val_r <= DW'(in_value);
        pos_r <= in_position;
        rd_r  <= '0;
        hit_r <= 1'b0;
      end
      OP_DECODE: begin
        kind_r   <= dec_kind;
        status_r <= dec_status;
        at_r     <= dec_at;
        idx_r    <= (dec_kind == KIND_INS) ? count_r :
                    ((dec_kind == KIND_FIND) ? '0 : dec_at);
      end
      OP_MOVE_WR: begin
        if (kind_r == KIND_INS) begin
          idx_r <= idx_r - CW'(1);
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
      OP_GET_CAP: rd_r <= $signed(ram_rdata);
      OP_FIND_CMP: begin
        if (ram_rdata == val_r) hit_r <= 1'b1;
        idx_r <= idx_r + CW'(1);
      end
      OP_BACK_RD:  front_r <= $signed(ram_rdata);
      OP_BACK_CAP: back_r  <= $signed(ram_rdata);
      OP_OUT: begin
        out_status      <= status_r;
        out_read_value  <= VAL_W'(rd_r);
        out_found       <= hit_r;
        out_front_value <= empty ? '0 : VAL_W'(front_r);
        out_back_value  <= empty ? '0 : VAL_W'(back_r);
        out_entry_count <= CNT_W'(count_r);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_ordered_list_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_unit
// Self-checking bench for the ordered list engine. A shadow list predicts
// every result word from the accepted command stream. Directed tests cover
// empty, full and index errors and the ends of the value range. A random
// phase then keeps the list moving between empty and full, first while both
// channels throttle at random, then in a last run with no throttling.
// ----------------------------------------------------------------------------

module tb_ordered_list_engine_unit;
  import ole_pkg::*;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 60;

  // Expected result word
  typedef struct packed {
    ole_status_t             status;
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic [CNT_W-1:0]        entry_count;
  } list_result_t;

  logic clk;
  logic rst_n;

  ole_in_if  in_chan ();
  ole_out_if out_chan ();

  ordered_list_engine_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow list, front at index 0
  logic signed [VAL_W-1:0] shadow_list[$];
  list_result_t            pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int stall_cycles;

  // Clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the shadow list and return the result word
  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [VAL_W-1:0] val,
                                                  input logic [POS_W-1:0] pos);
    list_result_t res;
    int           cnt;
    cnt = shadow_list.size();
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (cnt >= LIST_CAP) begin
          res.status = ST_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          shadow_list.push_front(val);
        end else if (cmd == CMD_PUSH_BACK || pos >= cnt) begin
          shadow_list.push_back(val);
        end else begin
          shadow_list.insert(pos, val);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (cmd == CMD_POP_FRONT) begin
          void'(shadow_list.pop_front());
        end else begin
          void'(shadow_list.pop_back());
        end
      end
      CMD_REMOVE: begin
        // empty wins over a bad index
        if (cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= cnt) begin
          res.status = ST_INDEX;
        end else begin
          shadow_list.delete(pos);
        end
      end
      CMD_GET: begin
        if (cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= cnt) begin
          res.status = ST_INDEX;
        end else begin
          res.read_value = shadow_list[pos];
        end
      end
      CMD_FIND: begin
        foreach (shadow_list[i]) begin
          if (shadow_list[i] == val) res.found = 1'b1;
        end
      end
      CMD_CLEAR: begin
        shadow_list.delete();
      end
      default: ; // unknown codes leave the list alone
    endcase
    cnt = shadow_list.size();
    if (cnt != 0) begin
      res.front_value = shadow_list[0];
      res.back_value  = shadow_list[cnt-1];
    end
    res.entry_count = cnt[CNT_W-1:0];
    return res;
  endfunction

  // Send one command word; valid stays up after the accept so that
  // back-to-back words never toggle it within one step
  task automatic send_word(input logic [CMD_W-1:0] cmd,
                           input logic signed [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.command  <= cmd;
    in_chan.value    <= val;
    in_chan.position <= pos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_results.push_back(apply_list_cmd(cmd, val, pos));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random word, weighted toward the range ends
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Error codes, range ends and index placement on a short list
  task automatic test_directed();
    send_word(CMD_POP_FRONT, 32'sd1, 5'd0);
    send_word(CMD_POP_BACK, 32'sd2, 5'd0);
    send_word(CMD_REMOVE, 32'sd3, 5'd16);
    send_word(CMD_GET, 32'sd4, 5'd0);
    send_word(CMD_FIND, 32'sd0, 5'd0);
    send_word(CMD_CLEAR, 32'sd0, 5'd0);
    send_word(4'd9, 32'sd5, 5'd1);
    send_word(4'd15, -32'sd1, 5'd31);
    send_word(CMD_PUSH_BACK, 32'sh7FFF_FFFF, 5'd0);
    send_word(CMD_PUSH_FRONT, 32'sh8000_0000, 5'd0);
    send_word(CMD_INSERT, -32'sd1, 5'd0);
    send_word(CMD_INSERT, 32'sd0, 5'd31);
    send_word(CMD_INSERT, 32'sh5555_AAAA, 5'd2);
    send_word(CMD_GET, 32'sd0, 5'd4);
    send_word(CMD_GET, 32'sd0, 5'd5);
    send_word(CMD_GET, 32'sd0, 5'd31);
    send_word(CMD_FIND, 32'sh8000_0000, 5'd0);
    send_word(CMD_FIND, 32'sd123, 5'd0);
    send_word(CMD_REMOVE, 32'sd0, 5'd4);
    send_word(CMD_REMOVE, 32'sd0, 5'd31);
    send_word(CMD_REMOVE, 32'sd0, 5'd0);
    send_word(CMD_POP_FRONT, 32'sd0, 5'd0);
    send_word(CMD_POP_BACK, 32'sd0, 5'd0);
    send_word(CMD_CLEAR, 32'sd0, 5'd0);
  endtask

  // Fill to capacity, hit the full errors, work the last index, drain
  task automatic test_full_list();
    for (int i = 0; i < LIST_CAP; i++) send_word(CMD_PUSH_BACK, pick_value(), 5'd0);
    send_word(CMD_PUSH_FRONT, 32'sd7, 5'd0);
    send_word(CMD_PUSH_BACK, 32'sd7, 5'd0);
    send_word(CMD_INSERT, 32'sd7, 5'd0);
    send_word(CMD_INSERT, 32'sd7, 5'd16);
    send_word(CMD_GET, 32'sd0, 5'd15);
    send_word(CMD_GET, 32'sd0, 5'd16);
    send_word(CMD_REMOVE, 32'sd0, 5'd16);
    send_word(CMD_REMOVE, 32'sd0, 5'd15);
    send_word(CMD_INSERT, 32'sh8000_0000, 5'd15);
    send_word(CMD_REMOVE, 32'sd0, 5'd0);
    send_word(CMD_INSERT, 32'sh7FFF_FFFF, 5'd0);
    for (int i = 0; i < LIST_CAP; i++) begin
      send_word((i % 2) ? CMD_POP_BACK : CMD_POP_FRONT, 32'sd0, 5'd0);
    end
  endtask

  // Random mix that wanders between empty and full
  task automatic test_random_mix(input int n_words);
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    int                      cnt;
    int                      r;
    for (int k = 0; k < n_words; k++) begin
      cnt = shadow_list.size();
      r   = $urandom_range(99);
      if (r < 3) begin
        cmd = CMD_CLEAR;
      end else if (r < 6) begin
        cmd = CMD_W'($urandom_range(9, 15));
      end else if (r < 15) begin
        cmd = CMD_GET;
      end else if (r < 24) begin
        cmd = CMD_FIND;
      end else if (cnt < $urandom_range(0, LIST_CAP + 2)) begin
        case ($urandom_range(2))
          0:       cmd = CMD_PUSH_FRONT;
          1:       cmd = CMD_PUSH_BACK;
          default: cmd = CMD_INSERT;
        endcase
      end else begin
        case ($urandom_range(2))
          0:       cmd = CMD_POP_FRONT;
          1:       cmd = CMD_POP_BACK;
          default: cmd = CMD_REMOVE;
        endcase
      end
      val = pick_value();
      // find an entry that is there half the time
      if (cmd == CMD_FIND && cnt != 0 && $urandom_range(1)) begin
        val = shadow_list[$urandom_range(cnt - 1)];
      end
      if ($urandom_range(4) == 0) pos = POS_W'($urandom_range(31));
      else pos = POS_W'($urandom_range(0, cnt));
      send_word(cmd, val, pos);
    end
  endtask

  // Result checker and receiver throttle
  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_chan.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_chan.status);
          error_count++;
        end
        if (out_chan.read_value !== exp_res.read_value) begin
          $error("read_value: expected %0d, got %0d", exp_res.read_value,
                 out_chan.read_value);
          error_count++;
        end
        if (out_chan.found !== exp_res.found) begin
          $error("found: expected %0d, got %0d", exp_res.found, out_chan.found);
          error_count++;
        end
        if (out_chan.front_value !== exp_res.front_value) begin
          $error("front_value: expected %0d, got %0d", exp_res.front_value,
                 out_chan.front_value);
          error_count++;
        end
        if (out_chan.back_value !== exp_res.back_value) begin
          $error("back_value: expected %0d, got %0d", exp_res.back_value,
                 out_chan.back_value);
          error_count++;
        end
        if (out_chan.entry_count !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_res.entry_count,
                 out_chan.entry_count);
          error_count++;
        end
      end
    end
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Test sequence
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.command  = '0;
    in_chan.value    = '0;
    in_chan.position = '0;
    out_chan.ready   = 1'b0;
    send_idle_pct    = 38;
    recv_idle_pct    = 76;
    error_count      = 0;
    stall_cycles     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_list();
    test_random_mix(160);
    send_idle_pct = 76;
    recv_idle_pct = 38;
    test_random_mix(160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(163);
    in_chan.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
